### rtl/baro_pkg.sv
// Shared types and constants of the barometric compensation block.
// Depends on nothing; every other file imports it.
`default_nettype none

package baro_pkg;

  localparam int unsigned QUEUE_DEPTH = 4;

  localparam logic [25:0] TF_OFFSET = 26'd128000;
  localparam logic [20:0] P_FULL    = 21'd1048576;
  localparam logic [55:0] WHOLE_MAX = 56'd134218;
  localparam logic [26:0] PRES_MAX  = 27'd134217727;
  localparam logic signed [19:0] TEMP_MAX = 20'sd32767;
  localparam logic signed [19:0] TEMP_MIN = -20'sd32768;

  typedef enum logic [2:0] {
    CFG_T1      = 3'd0,
    CFG_T2_T3   = 3'd1,
    CFG_P1      = 3'd2,
    CFG_P2_TO_5 = 3'd3,
    CFG_P6_TO_9 = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    logic [19:0] temperature_raw;
    logic [19:0] pressure_raw;
  } baro_in_t;

  typedef struct packed {
    logic signed [15:0] temperature_centi;
    logic [26:0]        pressure_milli_pa;
    logic               divide_by_zero;
  } baro_out_t;

  typedef struct packed {
    logic [15:0] t1;
    logic [31:0] t2_t3;
    logic [15:0] p1;
    logic [63:0] p2_to_p5;
    logic [63:0] p6_to_p9;
  } baro_cfg_t;

  // Item after the front end: raw pressure and the two temperature differences.
  typedef struct packed {
    logic [19:0]        adc_p;
    logic signed [17:0] d1;
    logic signed [16:0] d2;
  } baro_item_t;

  // Values that ride alongside the divider.
  typedef struct packed {
    logic [15:0] tc;
    logic        dz;
    logic        neg;
  } baro_side_t;

endpackage

`default_nettype wire

### rtl/baro_front.sv
// Front end: input register that forms the temperature differences.
// Depends on baro_pkg; feeds baro_queue.
`default_nettype none

module baro_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  baro_pkg::baro_in_t   in_data,
  input  logic [15:0]          cal_t1,
  input  logic                 q_full,
  output logic                 push,
  output baro_pkg::baro_item_t item
);
  import baro_pkg::*;

  logic       fr_valid_r;
  baro_item_t fr_item_r;
  baro_item_t fr_item_nxt;
  logic       load;

  assign in_stall = fr_valid_r & q_full;
  assign push     = fr_valid_r & ~q_full;
  assign load     = ~fr_valid_r | push;
  assign item     = fr_item_r;

  always_comb begin
    fr_item_nxt.adc_p = in_data.pressure_raw;
    fr_item_nxt.d1    = $signed({1'b0, in_data.temperature_raw[19:3]})
                      - $signed({1'b0, cal_t1, 1'b0});
    fr_item_nxt.d2    = $signed({1'b0, in_data.temperature_raw[19:4]})
                      - $signed({1'b0, cal_t1});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fr_valid_r <= 1'b0;
    end else if (load) begin
      fr_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load && in_valid) begin
      fr_item_r <= fr_item_nxt;
    end
  end

endmodule

`default_nettype wire

### rtl/baro_queue.sv
// Short first-in first-out queue between the front end and the datapath.
// Depends on baro_pkg for the item type.
`default_nettype none

module baro_queue #(
  parameter int unsigned DEPTH = baro_pkg::QUEUE_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  baro_pkg::baro_item_t wr_item,
  input  logic                 pop,
  output logic                 q_valid,
  output logic                 q_full,
  output baro_pkg::baro_item_t rd_item
);
  import baro_pkg::*;

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

  baro_item_t    mem [DEPTH];
  logic [PW-1:0] wr_ptr_r;
  logic [PW-1:0] rd_ptr_r;
  logic [CW-1:0] cnt_r;

  assign q_valid = (cnt_r != '0);
  assign q_full  = (cnt_r == CNT_FULL);
  assign rd_item = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= wr_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

### rtl/baro_div.sv
// Pipelined restoring divider, one quotient bit per stage, 64 stages.
// Depends on baro_pkg for the side-band type.
`default_nettype none

module baro_div (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 in_valid,
  input  logic [63:0]          in_dvd,
  input  logic [30:0]          in_dvs,
  input  baro_pkg::baro_side_t in_side,
  output logic                 out_valid,
  output logic [63:0]          out_quo,
  output baro_pkg::baro_side_t out_side
);
  import baro_pkg::*;

  localparam int unsigned NST = 64;

  logic       v_r    [NST];
  logic [63:0] dvd_r [NST];
  logic [30:0] rem_r [NST];
  logic [30:0] dvs_r [NST];
  baro_side_t side_r [NST];

  genvar gi;
  for (gi = 0; gi < NST; gi++) begin : g_st
    logic        v_in;
    logic [63:0] dvd_in;
    logic [30:0] rem_in;
    logic [30:0] dvs_in;
    baro_side_t  side_in;
    logic [31:0] trial;
    logic [31:0] diff;
    logic        ge;

    if (gi == 0) begin : g_first
      assign v_in    = in_valid;
      assign dvd_in  = in_dvd;
      assign rem_in  = '0;
      assign dvs_in  = in_dvs;
      assign side_in = in_side;
    end else begin : g_next
      assign v_in    = v_r[gi-1];
      assign dvd_in  = dvd_r[gi-1];
      assign rem_in  = rem_r[gi-1];
      assign dvs_in  = dvs_r[gi-1];
      assign side_in = side_r[gi-1];
    end

    assign trial = {rem_in, dvd_in[63]};
    assign diff  = trial - {1'b0, dvs_in};
    assign ge    = (trial >= {1'b0, dvs_in});

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[gi] <= 1'b0;
      end else if (en) begin
        v_r[gi] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dvd_r[gi]  <= {dvd_in[62:0], ge};
        rem_r[gi]  <= ge ? diff[30:0] : trial[30:0];
        dvs_r[gi]  <= dvs_in;
        side_r[gi] <= side_in;
      end
    end
  end

  assign out_valid = v_r[NST-1];
  assign out_quo   = dvd_r[NST-1];
  assign out_side  = side_r[NST-1];

endmodule

`default_nettype wire

### rtl/baro_back.sv
// Compensation datapath: temperature, pressure terms, divider and scaling.
// Depends on baro_pkg and instantiates baro_div.
`default_nettype none

module baro_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  baro_pkg::baro_cfg_t  cfg,
  input  logic                 q_valid,
  input  baro_pkg::baro_item_t q_item,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_stall,
  output baro_pkg::baro_out_t  out_data
);
  import baro_pkg::*;

  logic signed [15:0] t2, t3, p2, p3, p4, p5, p6, p7, p8, p9;
  assign t2 = cfg.t2_t3[15:0];
  assign t3 = cfg.t2_t3[31:16];
  assign p2 = cfg.p2_to_p5[15:0];
  assign p3 = cfg.p2_to_p5[31:16];
  assign p4 = cfg.p2_to_p5[47:32];
  assign p5 = cfg.p2_to_p5[63:48];
  assign p6 = cfg.p6_to_p9[15:0];
  assign p7 = cfg.p6_to_p9[31:16];
  assign p8 = cfg.p6_to_p9[47:32];
  assign p9 = cfg.p6_to_p9[63:48];

  logic en;
  logic [8:0] v_r;
  logic [4:0] w_r;
  logic       div_v;

  // The whole pipeline moves together; it holds only while a result waits.
  assign en  = ~(w_r[4] & out_stall);
  assign pop = en & q_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
      w_r <= '0;
    end else if (en) begin
      v_r <= {v_r[7:0], q_valid};
      w_r <= {w_r[3:0], div_v};
    end
  end

  // Stage 1: temperature products.
  logic signed [33:0] s1_m1_r, s1_m2_r;
  logic [19:0]        s1_adcp_r;
  always_ff @(posedge clk) begin
    if (en) begin
      s1_m1_r   <= q_item.d1 * t2;
      s1_m2_r   <= q_item.d2 * q_item.d2;
      s1_adcp_r <= q_item.adc_p;
    end
  end

  // Stage 2
  logic signed [22:0] s2_a_r;
  logic signed [37:0] s2_m3_r;
  logic [19:0]        s2_adcp_r;
  logic signed [21:0] s2_q;
  assign s2_q = $signed({1'b0, s1_m2_r[32:12]});
  always_ff @(posedge clk) begin
    if (en) begin
      s2_a_r    <= s1_m1_r[33:11];
      s2_m3_r   <= s2_q * t3;
      s2_adcp_r <= s1_adcp_r;
    end
  end

  // Stage 3: fine temperature.
  logic signed [24:0] s3_tf_r;
  logic [19:0]        s3_adcp_r;
  logic signed [23:0] s3_b;
  assign s3_b = s2_m3_r[37:14];
  always_ff @(posedge clk) begin
    if (en) begin
      s3_tf_r   <= 25'(s2_a_r) + 25'(s3_b);
      s3_adcp_r <= s2_adcp_r;
    end
  end

  // Stage 4: centi-degrees with saturation, offset fine temperature.
  logic signed [27:0] s4_t5;
  logic signed [19:0] s4_ts;
  logic [15:0]        s4_tc;
  always_comb begin
    s4_t5 = (28'(s3_tf_r) <<< 2) + 28'(s3_tf_r) + 28'sd128;
    s4_ts = s4_t5[27:8];
    if (s4_ts > TEMP_MAX) begin
      s4_tc = TEMP_MAX[15:0];
    end else if (s4_ts < TEMP_MIN) begin
      s4_tc = TEMP_MIN[15:0];
    end else begin
      s4_tc = s4_ts[15:0];
    end
  end

  logic signed [25:0] s4_v1_r;
  logic [15:0]        s4_tc_r;
  logic [19:0]        s4_adcp_r;
  always_ff @(posedge clk) begin
    if (en) begin
      s4_v1_r   <= 26'(s3_tf_r) - $signed(TF_OFFSET);
      s4_tc_r   <= s4_tc;
      s4_adcp_r <= s3_adcp_r;
    end
  end

  // Stage 5
  logic signed [51:0] s5_sq_r;
  logic signed [41:0] s5_m5_r, s5_m2_r;
  logic [15:0]        s5_tc_r;
  logic [19:0]        s5_adcp_r;
  always_ff @(posedge clk) begin
    if (en) begin
      s5_sq_r   <= s4_v1_r * s4_v1_r;
      s5_m5_r   <= s4_v1_r * p5;
      s5_m2_r   <= s4_v1_r * p2;
      s5_tc_r   <= s4_tc_r;
      s5_adcp_r <= s4_adcp_r;
    end
  end

  // Stage 6: square terms, kept modulo 2^64.
  logic signed [67:0] s6_x6, s6_x3;
  assign s6_x6 = s5_sq_r * p6;
  assign s6_x3 = s5_sq_r * p3;
  logic [63:0]        s6_x6_r, s6_x3_r;
  logic signed [41:0] s6_m5_r, s6_m2_r;
  logic [15:0]        s6_tc_r;
  logic [19:0]        s6_adcp_r;
  always_ff @(posedge clk) begin
    if (en) begin
      s6_x6_r   <= s6_x6[63:0];
      s6_x3_r   <= s6_x3[63:0];
      s6_m5_r   <= s5_m5_r;
      s6_m2_r   <= s5_m2_r;
      s6_tc_r   <= s5_tc_r;
      s6_adcp_r <= s5_adcp_r;
    end
  end

  // Stage 7
  logic [63:0] s7_v2_r, s7_u_r;
  logic [15:0] s7_tc_r;
  logic [19:0] s7_adcp_r;
  logic [63:0] s7_x3s;
  assign s7_x3s = $signed(s6_x3_r) >>> 8;
  always_ff @(posedge clk) begin
    if (en) begin
      s7_v2_r   <= s6_x6_r + (64'($signed(s6_m5_r)) << 17) + (64'($signed(p4)) << 35);
      s7_u_r    <= s7_x3s + (64'($signed(s6_m2_r)) << 12);
      s7_tc_r   <= s6_tc_r;
      s7_adcp_r <= s6_adcp_r;
    end
  end

  // Stage 8: divisor and numerator products.
  logic [20:0] s8_p;
  logic [79:0] s8_w;
  logic [75:0] s8_n;
  assign s8_p = P_FULL - {1'b0, s7_adcp_r};
  assign s8_w = (s7_u_r + 64'h0000_8000_0000_0000) * cfg.p1;
  assign s8_n = (({43'd0, s8_p} << 31) - s7_v2_r) * 12'd3125;
  logic [63:0] s8_w_r, s8_n_r;
  logic [15:0] s8_tc_r;
  always_ff @(posedge clk) begin
    if (en) begin
      s8_w_r  <= s8_w[63:0];
      s8_n_r  <= s8_n[63:0];
      s8_tc_r <= s7_tc_r;
    end
  end

  // Stage 9: signs and magnitudes for the divider.
  logic [30:0] s9_den;
  logic        s9_dz;
  assign s9_den = s8_w_r[63:33];
  assign s9_dz  = (s9_den == '0);
  logic [63:0] s9_ma_r;
  logic [30:0] s9_mb_r;
  baro_side_t  s9_side_r;
  always_ff @(posedge clk) begin
    if (en) begin
      s9_ma_r <= s8_n_r[63] ? (64'd0 - s8_n_r) : s8_n_r;
      if (s9_dz) begin
        s9_mb_r <= 31'd1;
      end else begin
        s9_mb_r <= s9_den[30] ? (31'd0 - s9_den) : s9_den;
      end
      s9_side_r.tc  <= s8_tc_r;
      s9_side_r.dz  <= s9_dz;
      s9_side_r.neg <= s8_n_r[63] ^ s9_den[30];
    end
  end

  logic [63:0] div_q;
  baro_side_t  div_side;
  baro_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (v_r[8]),
    .in_dvd    (s9_ma_r),
    .in_dvs    (s9_mb_r),
    .in_side   (s9_side_r),
    .out_valid (div_v),
    .out_quo   (div_q),
    .out_side  (div_side)
  );

  // After the divider: apply the sign.
  logic [63:0] w0_p_r;
  baro_side_t  w0_side_r;
  always_ff @(posedge clk) begin
    if (en) begin
      w0_p_r    <= div_side.neg ? (64'd0 - div_q) : div_q;
      w0_side_r <= div_side;
    end
  end

  // Square of p >> 13 split into halves of its 64-bit sign extension; only
  // the low 64 bits matter.
  logic [50:0] w1_s;
  logic [31:0] w1_hi;
  logic [63:0] w1_ll;
  logic [63:0] w1_lh;
  logic [79:0] w1_bm;
  assign w1_s  = w0_p_r[63:13];
  assign w1_hi = 32'($signed(w1_s[50:32]));
  assign w1_ll = w1_s[31:0] * w1_s[31:0];
  assign w1_lh = w1_s[31:0] * w1_hi;
  assign w1_bm = $signed(w0_p_r) * p8;
  logic [63:0] w1_p_r, w1_ll_r, w1_bm_r;
  logic [30:0] w1_lh_r;
  baro_side_t  w1_side_r;
  always_ff @(posedge clk) begin
    if (en) begin
      w1_p_r    <= w0_p_r;
      w1_ll_r   <= w1_ll;
      w1_lh_r   <= w1_lh[30:0];
      w1_bm_r   <= w1_bm[63:0];
      w1_side_r <= w0_side_r;
    end
  end

  logic [63:0] w2_ss;
  logic [79:0] w2_am;
  assign w2_ss = w1_ll_r + {w1_lh_r, 33'd0};
  assign w2_am = $signed(w2_ss) * p9;
  logic [63:0] w2_p_r, w2_am_r, w2_bm_r;
  baro_side_t  w2_side_r;
  always_ff @(posedge clk) begin
    if (en) begin
      w2_p_r    <= w1_p_r;
      w2_am_r   <= w2_am[63:0];
      w2_bm_r   <= w1_bm_r;
      w2_side_r <= w1_side_r;
    end
  end

  // Q56.8 pressure.
  logic [63:0] w3_a, w3_b, w3_sum, w3_sh;
  assign w3_a   = $signed(w2_am_r) >>> 25;
  assign w3_b   = $signed(w2_bm_r) >>> 19;
  assign w3_sum = w2_p_r + w3_a + w3_b;
  assign w3_sh  = $signed(w3_sum) >>> 8;
  logic [63:0] w3_pf_r;
  baro_side_t  w3_side_r;
  always_ff @(posedge clk) begin
    if (en) begin
      w3_pf_r   <= w3_sh + (64'($signed(p7)) << 4);
      w3_side_r <= w2_side_r;
    end
  end

  // Conversion to milliPascal: the fraction times 390625/100000 is x*125/32.
  logic [14:0] o_fr;
  logic [27:0] o_sum;
  logic [26:0] o_pres;
  always_comb begin
    o_fr  = w3_pf_r[7:0] * 7'd125;
    o_sum = w3_pf_r[25:8] * 10'd1000 + 28'(o_fr[14:5]);
    if (w3_side_r.dz || w3_pf_r[63]) begin
      o_pres = '0;
    end else if (w3_pf_r[63:8] > WHOLE_MAX || o_sum > 28'(PRES_MAX)) begin
      o_pres = PRES_MAX;
    end else begin
      o_pres = o_sum[26:0];
    end
  end

  baro_out_t out_r;
  always_ff @(posedge clk) begin
    if (en) begin
      out_r.temperature_centi <= w3_side_r.tc;
      out_r.pressure_milli_pa <= o_pres;
      out_r.divide_by_zero    <= w3_side_r.dz;
    end
  end

  assign out_valid = w_r[4];
  assign out_data  = out_r;

endmodule

`default_nettype wire

### rtl/baro_temp_pressure_compensation.sv
// Top level of the barometric temperature and pressure compensation block.
// Depends on baro_pkg, baro_front, baro_queue and baro_back.
`default_nettype none

//  Channel  | Ports                                | Moves
//  ---------+--------------------------------------+-----------------------------
//  input    | in_valid, in_stall, in_data          | raw temperature and pressure
//  result   | out_valid, out_stall, out_data       | compensated reading and flag
//  config   | cfg_valid, cfg_ready, cfg_index/data | calibration coefficients
//
// One transfer is accepted every cycle while in_stall is low; between an input
// transfer and its result lie the front-end register, the queue, nine stages
// of multiply before the 64-stage divider and five stages of sign, scaling and
// output register after it.
// Reset (rst_n low, synchronous) clears all valid state and the coefficients.
// A stall on the result side freezes the datapath; the queue behind the
// front end then fills, and only when it is full is in_stall raised.

module baro_temp_pressure_compensation #(
  parameter int unsigned QUEUE_DEPTH = baro_pkg::QUEUE_DEPTH
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  baro_pkg::baro_in_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output baro_pkg::baro_out_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [2:0]          cfg_index,
  input  logic [63:0]         cfg_data
);
  import baro_pkg::*;

  // Calibration registers; writes must arrive only while the block is idle (not enforced).
  baro_cfg_t cfg_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_T1:      cfg_r.t1       <= cfg_data[15:0];
        CFG_T2_T3:   cfg_r.t2_t3    <= cfg_data[31:0];
        CFG_P1:      cfg_r.p1       <= cfg_data[15:0];
        CFG_P2_TO_5: cfg_r.p2_to_p5 <= cfg_data;
        CFG_P6_TO_9: cfg_r.p6_to_p9 <= cfg_data;
        default: ;
      endcase
    end
  end

  // Front end: accepts transfers and forms the temperature differences.
  logic       push;
  logic       q_full;
  logic       q_valid;
  logic       pop;
  baro_item_t fr_item;
  baro_item_t q_item;

  baro_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .cal_t1   (cfg_r.t1),
    .q_full   (q_full),
    .push     (push),
    .item     (fr_item)
  );

  // The queue lets the front keep accepting while the datapath is held.
  baro_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .wr_item (fr_item),
    .pop     (pop),
    .q_valid (q_valid),
    .q_full  (q_full),
    .rd_item (q_item)
  );

  // Back end: the full compensation pipeline with its output register.
  baro_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // A zero divisor always forces the pressure to zero.
  a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.divide_by_zero |-> out_data.pressure_milli_pa == '0)
    else $error("pressure not zero on divide by zero");

  // The input side is held back only because the queue is full.
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> q_full && q_valid)
    else $error("input stalled while queue has room");

  // Nothing is taken from an empty queue.
  a_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> q_valid)
    else $error("pop from empty queue");

endmodule

`default_nettype wire

### bench/baro_temp_pressure_compensation_tb.sv
// Self-checking bench for baro_temp_pressure_compensation: a scoreboard with
// its own 64-bit integer compensation predicts every reading and checks it.
// Depends on baro_pkg and the block's RTL only.
`default_nettype none

module baro_temp_pressure_compensation_tb;
  import baro_pkg::*;

  // Holds the expected readings in transfer order together with a private
  // copy of the calibration, and predicts each reading from its raw pair.
  class reading_board;
    baro_cfg_t cal;
    baro_out_t expected_readings[$];
    int unsigned mismatches;

    function new();
      cal = '0;
      mismatches = 0;
    endfunction

    function void write_cal(logic [2:0] idx, logic [63:0] value);
      case (idx)
        CFG_T1:      cal.t1       = value[15:0];
        CFG_T2_T3:   cal.t2_t3    = value[31:0];
        CFG_P1:      cal.p1       = value[15:0];
        CFG_P2_TO_5: cal.p2_to_p5 = value;
        CFG_P6_TO_9: cal.p6_to_p9 = value;
        default: ;
      endcase
    endfunction

    function logic [63:0] lane(logic [15:0] v);
      return {{48{v[15]}}, v};
    endfunction

    function logic [63:0] asr(logic [63:0] v, int n);
      return $signed(v) >>> n;
    endfunction

    function baro_out_t compensate(baro_in_t x);
      logic [63:0] at, ap, t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
      logic [63:0] a, b, d, v1, v2, p, tf, num, ma, mb, q, whole, frac, pres;
      longint ts;
      baro_out_t r;
      at = 64'(x.temperature_raw);
      ap = 64'(x.pressure_raw);
      t1 = 64'(cal.t1);
      t2 = lane(cal.t2_t3[15:0]);
      t3 = lane(cal.t2_t3[31:16]);
      p1 = 64'(cal.p1);
      p2 = lane(cal.p2_to_p5[15:0]);
      p3 = lane(cal.p2_to_p5[31:16]);
      p4 = lane(cal.p2_to_p5[47:32]);
      p5 = lane(cal.p2_to_p5[63:48]);
      p6 = lane(cal.p6_to_p9[15:0]);
      p7 = lane(cal.p6_to_p9[31:16]);
      p8 = lane(cal.p6_to_p9[47:32]);
      p9 = lane(cal.p6_to_p9[63:48]);
      r = '0;

      // Temperature: exact in 64 bits, arithmetic shifts throughout.
      d = (at >> 3) - (t1 << 1);
      a = asr(d * t2, 11);
      d = (at >> 4) - t1;
      b = asr(asr(d * d, 12) * t3, 14);
      tf = a + b;
      ts = $signed(asr(tf * 64'd5 + 64'd128, 8));
      if (ts > 32767) ts = 32767;
      if (ts < -32768) ts = -32768;
      r.temperature_centi = ts[15:0];

      // Pressure: wrapping 64-bit datapath.
      v1 = tf - 64'd128000;
      v2 = v1 * v1 * p6;
      v2 = v2 + ((v1 * p5) << 17);
      v2 = v2 + (p4 << 35);
      v1 = asr(v1 * v1 * p3, 8) + ((v1 * p2) << 12);
      v1 = asr(((64'd1 << 47) + v1) * p1, 33);
      if (v1 == 64'd0) begin
        r.divide_by_zero = 1'b1;
        pres = 64'd0;
      end else begin
        p = 64'd1048576 - ap;
        num = ((p << 31) - v2) * 64'd3125;
        // Truncating signed division done on magnitudes, so that the most
        // negative value divided by minus one wraps to itself.
        ma = num[63] ? 64'd0 - num : num;
        mb = v1[63] ? 64'd0 - v1 : v1;
        q = ma / mb;
        p = (num[63] != v1[63]) ? 64'd0 - q : q;
        a = asr(p9 * asr(p, 13) * asr(p, 13), 25);
        b = asr(p8 * p, 19);
        p = asr(p + a + b, 8) + (p7 << 4);
        if (p[63]) begin
          pres = 64'd0;
        end else begin
          whole = p >> 8;
          frac = ((p & 64'hFF) * 64'd390625) / 64'd100000;
          if (whole > 64'd134218) begin
            pres = 64'(PRES_MAX);
          end else begin
            pres = whole * 64'd1000 + frac;
            if (pres > 64'(PRES_MAX)) pres = 64'(PRES_MAX);
          end
        end
      end
      r.pressure_milli_pa = pres[26:0];
      return r;
    endfunction

    function void note_sample(baro_in_t x);
      expected_readings.push_back(compensate(x));
    endfunction

    function void check_reading(baro_out_t got);
      baro_out_t want;
      if (expected_readings.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Unexpected reading: %p", got);
        return;
      end
      want = expected_readings.pop_front();
      if (got.temperature_centi !== want.temperature_centi ||
          got.pressure_milli_pa !== want.pressure_milli_pa ||
          got.divide_by_zero !== want.divide_by_zero) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Reading mismatch: expected t=%0d p=%0d dz=%0b, got t=%0d p=%0d dz=%0b",
                   want.temperature_centi, want.pressure_milli_pa, want.divide_by_zero,
                   got.temperature_centi, got.pressure_milli_pa, got.divide_by_zero);
      end
    endfunction
  endclass

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  baro_in_t   in_data;
  logic       out_valid;
  logic       out_stall;
  baro_out_t  out_data;
  logic       cfg_valid;
  logic       cfg_ready;
  logic [2:0] cfg_index;
  logic [63:0] cfg_data;

  reading_board board;

  // Percentages of cycles in which the sender idles and the receiver stalls.
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;

  baro_temp_pressure_compensation uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // The receiver stalls at random at the rate chosen for the current phase.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // Every transfer is observed here, on the values present before the edge,
  // so the scoreboard sees calibration writes, samples and readings in the
  // order in which the block takes them.
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) board.write_cal(cfg_index, cfg_data);
      if (in_valid && !in_stall) board.note_sample(in_data);
      if (out_valid && !out_stall) board.check_reading(out_data);
    end
  end

  // Presents one raw pair, after a random idle stretch, and holds it until
  // the block takes it. Valid stays high into the next transfer.
  task automatic send_sample(input logic [19:0] t_raw, input logic [19:0] p_raw);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data.temperature_raw <= t_raw;
    in_data.pressure_raw <= p_raw;
    do @(posedge clk); while (in_stall);
  endtask

  // Drops valid and waits until every expected reading has come back, then
  // lets the pipeline run dry for the block's full latency.
  task automatic drain;
    in_valid <= 1'b0;
    @(posedge clk);
    while (board.expected_readings.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [63:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic load_cal(input logic [15:0] t1, input logic [31:0] t23,
                          input logic [15:0] p1, input logic [63:0] p25,
                          input logic [63:0] p69);
    write_reg(CFG_T1, {48'd0, t1});
    write_reg(CFG_T2_T3, {32'd0, t23});
    write_reg(CFG_P1, {48'd0, p1});
    write_reg(CFG_P2_TO_5, p25);
    write_reg(CFG_P6_TO_9, p69);
  endtask

  // A typical factory calibration, lightly disturbed when asked.
  task automatic load_typical(input bit jitter);
    logic [15:0] t1, t2, t3, p1;
    logic [15:0] pc [2:9];
    t1 = 16'd27504; t2 = 16'd26435; t3 = -16'sd1000; p1 = 16'd36477;
    pc[2] = -16'sd10685; pc[3] = 16'd3024; pc[4] = 16'd2855; pc[5] = 16'd140;
    pc[6] = -16'sd7; pc[7] = 16'd15500; pc[8] = -16'sd14600; pc[9] = 16'd6000;
    if (jitter) begin
      t1 = t1 + 16'($urandom_range(2000)) - 16'd1000;
      t2 = t2 + 16'($urandom_range(2000)) - 16'd1000;
      t3 = t3 + 16'($urandom_range(200)) - 16'd100;
      p1 = p1 + 16'($urandom_range(4000)) - 16'd2000;
      for (int k = 2; k <= 9; k++) pc[k] = pc[k] + 16'($urandom_range(64)) - 16'd32;
    end
    load_cal(t1, {t3, t2}, p1, {pc[5], pc[4], pc[3], pc[2]},
             {pc[9], pc[8], pc[7], pc[6]});
  endtask

  // Raw pairs: mostly readings a real sensor gives, the rest over the full range.
  task automatic send_random(input int unsigned count, input bit pause_midway);
    logic [19:0] t_raw, p_raw;
    for (int unsigned n = 0; n < count; n++) begin
      if ($urandom_range(99) < 70) begin
        t_raw = 20'($urandom_range(600000, 420000));
        p_raw = 20'($urandom_range(460000, 250000));
      end else begin
        t_raw = 20'($urandom);
        p_raw = 20'($urandom);
      end
      send_sample(t_raw, p_raw);
      if (pause_midway && n == count / 2) drain;
    end
  endtask

  initial begin
    board = new();
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Coefficients straight out of reset: the divisor is zero throughout.
    send_sample(20'd519888, 20'd415148);
    send_sample(20'hFFFFF, 20'd0);
    drain;

    // Directed pairs on a typical calibration: field extremes, a nominal
    // reading, and raw pressures that push the result negative or past full scale.
    load_typical(1'b0);
    write_reg(3'd5, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(3'd7, 64'h0);
    send_sample(20'd519888, 20'd415148);
    send_sample(20'd0, 20'd0);
    send_sample(20'hFFFFF, 20'hFFFFF);
    send_sample(20'd0, 20'hFFFFF);
    send_sample(20'hFFFFF, 20'd0);
    send_sample(20'h55555, 20'hAAAAA);
    send_sample(20'hAAAAA, 20'h55555);
    send_sample(20'd519888, 20'd0);
    send_sample(20'd519888, 20'hFFFFF);
    send_sample(20'd440000, 20'd300000);
    send_sample(20'd600000, 20'd450000);
    drain;

    // Coefficients at their extremes: all ones, then alternating most positive and most negative.
    load_cal(16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, '1, '1);
    send_sample(20'd0, 20'd0);
    send_sample(20'hFFFFF, 20'hFFFFF);
    send_sample(20'd519888, 20'd415148);
    drain;
    load_cal(16'hFFFF, 32'h7FFF_8000, 16'h0001, 64'h8000_7FFF_8000_7FFF,
             64'h7FFF_8000_7FFF_8000);
    send_sample(20'd0, 20'hFFFFF);
    send_sample(20'hFFFFF, 20'd0);
    send_sample(20'd262144, 20'd524288);
    drain;

    // Random phases, each on its own calibration, cycling through four traffic patterns.
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 76; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 76; end
        default: begin send_idle_pct = 14; recv_stall_pct = 14; end
      endcase
      if (ph < 6) load_typical(ph != 0);
      else load_cal(16'($urandom), $urandom, 16'($urandom),
                    {$urandom, $urandom}, {$urandom, $urandom});
      send_random(210, ph == 3);
      drain;
    end

    if (board.mismatches == 0 && board.expected_readings.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

`default_nettype wire
